[sv/apc_pkg.sv]
`default_nettype none
package apc_pkg;

  // Default structural widths.
  localparam int ADC_BITS_DEF  = 12;
  localparam int POS_BITS_DEF  = 16;
  localparam int TIME_BITS_DEF = 24;

  // Fixed register widths.
  localparam int CAL_W      = 13;
  localparam int STROKE_W   = 12;
  localparam int TIMEOUT_W  = 24;
  localparam int TOL_W      = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int KIND_W     = 2;
  localparam int CAUSE_W    = 2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CAL_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STROKE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOL      = 3'd4;

  // Register reset values.
  localparam logic [CAL_W-1:0]     CAL_LOW_RST  = 13'd0;
  localparam logic [CAL_W-1:0]     CAL_HIGH_RST = 13'd4096;
  localparam logic [STROKE_W-1:0]  STROKE_RST   = 12'd300;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST  = 24'd60000;
  localparam logic [TOL_W-1:0]     TOL_RST      = 12'd5;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_TICK = 2'd0;
  localparam logic [KIND_W-1:0] KIND_GOTO = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STOP = 2'd2;

  // Stop causes.
  localparam logic [CAUSE_W-1:0] CAUSE_NONE    = 2'd0;
  localparam logic [CAUSE_W-1:0] CAUSE_REACHED = 2'd1;
  localparam logic [CAUSE_W-1:0] CAUSE_TIMEOUT = 2'd2;
  localparam logic [CAUSE_W-1:0] CAUSE_STOP    = 2'd3;

  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // Width of the signed reading offset, and the number of quotient bits.
  function automatic int diff_width(input int adc_bits);
    return max_int(adc_bits, CAL_W) + 1;
  endfunction

  function automatic int quot_width(input int adc_bits);
    return diff_width(adc_bits) + STROKE_W;
  endfunction

  typedef struct packed {
    logic load;
    logic mul;
    logic init;
    logic step;
    logic sat;
    logic update;
  } apc_cmd_t;

endpackage
`default_nettype wire

[sv/apc_in_if.sv]
`default_nettype none
interface apc_in_if import apc_pkg::*; #(
  parameter int ADC_BITS = ADC_BITS_DEF,
  parameter int POS_BITS = POS_BITS_DEF
) ();
  logic                       valid;
  logic                       ready;
  logic [KIND_W-1:0]          kind;
  logic [ADC_BITS-1:0]        sample_value;
  logic signed [POS_BITS-1:0] goal_position;

  modport source (output valid, kind, sample_value, goal_position, input ready);
  modport sink (input valid, kind, sample_value, goal_position, output ready);
endinterface
`default_nettype wire

[sv/apc_out_if.sv]
`default_nettype none
interface apc_out_if import apc_pkg::*; #(
  parameter int POS_BITS = POS_BITS_DEF
) ();
  logic                       valid;
  logic                       ready;
  logic                       extend_drive;
  logic                       retract_drive;
  logic                       ready_flag;
  logic signed [POS_BITS-1:0] target_out;
  logic signed [POS_BITS-1:0] position_out;
  logic [CAUSE_W-1:0]         stop_cause;

  modport source (output valid, extend_drive, retract_drive, ready_flag, target_out,
                  position_out, stop_cause, input ready);
  modport sink (input valid, extend_drive, retract_drive, ready_flag, target_out,
                position_out, stop_cause, output ready);
endinterface
`default_nettype wire

[sv/actuator_position_controller.sv]
// A request's result is registered after it is accepted, in the steps multiply,
// division setup, 26 restoring division steps, saturation and update.
// Only one request is in flight; the divider resolves one quotient bit per cycle.
// A waiting result blocks acceptance; the update step waits for the output register.
// Reset (synchronous, rst high): configuration returns to defaults, drives off,
// ready set, target and elapsed count zero, no result pending.
`default_nettype none
module actuator_position_controller import apc_pkg::*; #(
  parameter int ADC_BITS  = ADC_BITS_DEF,
  parameter int POS_BITS  = POS_BITS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  apc_in_if.sink                     in_ch,
  apc_out_if.source                  out_ch,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DIV_STEPS = quot_width(ADC_BITS);

  apc_cmd_t cmd;
  logic     in_ready;
  logic     out_busy;

  assign in_ch.ready = in_ready;

  apc_ctrl #(
    .DIV_STEPS(DIV_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .out_busy (out_busy),
    .cmd      (cmd)
  );

  apc_dp #(
    .ADC_BITS (ADC_BITS),
    .POS_BITS (POS_BITS),
    .TIME_BITS(TIME_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .kind         (in_ch.kind),
    .sample_value (in_ch.sample_value),
    .goal_position(in_ch.goal_position),
    .cmd          (cmd),
    .out_busy     (out_busy),
    .out_ch       (out_ch)
  );

endmodule
`default_nettype wire

[sv/apc_ctrl.sv]
`default_nettype none
module apc_ctrl import apc_pkg::*; #(
  parameter int DIV_STEPS = quot_width(ADC_BITS_DEF)
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire logic out_busy,
  output apc_cmd_t  cmd
);

  localparam int CNT_W = $clog2(DIV_STEPS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_INIT = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_SAT  = 3'd4;
  localparam logic [2:0] S_UPD  = 3'd5;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [CNT_W-1:0] step_cnt;
  logic [CNT_W-1:0] step_cnt_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    cmd           = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_INIT;
      end
      S_INIT: begin
        cmd.init      = 1'b1;
        step_cnt_next = '0;
        state_next    = S_DIV;
      end
      S_DIV: begin
        cmd.step      = 1'b1;
        step_cnt_next = step_cnt + 1'b1;
        if (step_cnt == CNT_W'(DIV_STEPS - 1)) begin
          state_next = S_SAT;
        end
      end
      S_SAT: begin
        cmd.sat    = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        // Hold the finished result until the output register is free.
        if (!out_busy) begin
          cmd.update = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      step_cnt <= '0;
    end else begin
      state    <= state_next;
      step_cnt <= step_cnt_next;
    end
  end

  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst) $onehot0(cmd))
    else $error("more than one datapath command at once");

  a_div_then_sat: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && step_cnt == CNT_W'(DIV_STEPS - 1)) |=> cmd.sat)
    else $error("division did not end in the saturation step");

  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == S_MUL))
    else $error("accepted request did not start the multiply");

endmodule
`default_nettype wire

[sv/apc_dp.sv]
`default_nettype none
module apc_dp import apc_pkg::*; #(
  parameter int ADC_BITS  = ADC_BITS_DEF,
  parameter int POS_BITS  = POS_BITS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_write,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [CFG_DATA_W-1:0]      cfg_data,
  input  wire logic [KIND_W-1:0]          kind,
  input  wire logic [ADC_BITS-1:0]        sample_value,
  input  wire logic signed [POS_BITS-1:0] goal_position,
  input  wire apc_cmd_t                   cmd,
  output logic                            out_busy,
  apc_out_if.source                       out_ch
);

  localparam int DIFF_W  = diff_width(ADC_BITS);
  localparam int PROD_W  = DIFF_W + STROKE_W + 1;
  localparam int MAG_W   = quot_width(ADC_BITS);
  localparam int SAT_W   = max_int(MAG_W, POS_BITS) + 1;
  localparam int ERR_W   = POS_BITS + 1;
  localparam int ECMP_W  = max_int(ERR_W, TOL_W);
  localparam int TCMP_W  = max_int(TIME_BITS, TIMEOUT_W);

  localparam logic [SAT_W-1:0] POS_MAX_X = {{(SAT_W-POS_BITS+1){1'b0}},
                                            {(POS_BITS-1){1'b1}}};
  localparam logic [SAT_W-1:0] POS_MIN_MAG = POS_MAX_X + 1'b1;
  localparam logic signed [POS_BITS-1:0] POS_MAX_V = {1'b0, {(POS_BITS-1){1'b1}}};
  localparam logic signed [POS_BITS-1:0] POS_MIN_V = {1'b1, {(POS_BITS-1){1'b0}}};

  // Configuration registers.
  logic [CAL_W-1:0]     cal_low;
  logic [CAL_W-1:0]     cal_high;
  logic [STROKE_W-1:0]  stroke;
  logic [TIMEOUT_W-1:0] timeout;
  logic [TOL_W-1:0]     tolerance;

  // Captured request.
  logic [KIND_W-1:0]          kind_r;
  logic [ADC_BITS-1:0]        sample_r;
  logic signed [POS_BITS-1:0] goal_r;

  // Mapping datapath.
  logic signed [DIFF_W-1:0]   diff_s;
  logic signed [STROKE_W:0]   stroke_s;
  logic signed [PROD_W-1:0]   prod_r;
  logic [PROD_W-1:0]          prod_mag;
  logic signed [CAL_W:0]      span_s;
  logic [CAL_W:0]             span_abs;
  logic [CAL_W-1:0]           span_mag;
  logic                       span_neg;
  logic                       span_zero;
  logic                       quot_neg;
  logic [MAG_W-1:0]           quot;
  logic [CAL_W-1:0]           rem;
  logic [CAL_W:0]             rem_shift;
  logic                       rem_ge;
  logic [SAT_W-1:0]           quot_x;
  logic [SAT_W-1:0]           quot_neg_x;
  logic signed [POS_BITS-1:0] pos_r;

  // Controller state.
  logic signed [POS_BITS-1:0] target_reg;
  logic signed [POS_BITS-1:0] target_next;
  logic                       ready_reg;
  logic                       ready_next;
  logic                       extend_reg;
  logic                       extend_next;
  logic                       retract_reg;
  logic                       retract_next;
  logic [TIME_BITS-1:0]       elapsed;
  logic [TIME_BITS-1:0]       elapsed_next;
  logic [TIME_BITS-1:0]       elapsed_inc;
  logic [CAUSE_W-1:0]         cause_next;
  logic signed [ERR_W-1:0]    track_err;
  logic [ERR_W-1:0]           err_mag;
  logic signed [ERR_W-1:0]    goal_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_low   <= CAL_LOW_RST;
      cal_high  <= CAL_HIGH_RST;
      stroke    <= STROKE_RST;
      timeout   <= TIMEOUT_RST;
      tolerance <= TOL_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CAL_LOW:  cal_low   <= cfg_data[CAL_W-1:0];
        REG_CAL_HIGH: cal_high  <= cfg_data[CAL_W-1:0];
        REG_STROKE:   stroke    <= cfg_data[STROKE_W-1:0];
        REG_TIMEOUT:  timeout   <= cfg_data[TIMEOUT_W-1:0];
        REG_TOL:      tolerance <= cfg_data[TOL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign diff_s   = $signed({{(DIFF_W-ADC_BITS){1'b0}}, sample_r})
                  - $signed({{(DIFF_W-CAL_W){1'b0}}, cal_low});
  assign stroke_s = $signed({1'b0, stroke});
  assign span_s   = $signed({1'b0, cal_high}) - $signed({1'b0, cal_low});
  assign span_abs = span_s[CAL_W] ? (~span_s + 1'b1) : span_s;
  assign prod_mag = prod_r[PROD_W-1] ? (~prod_r + 1'b1) : prod_r;

  // One restoring division step per cycle on the magnitudes.
  assign rem_shift = {rem, quot[MAG_W-1]};
  assign rem_ge    = (rem_shift >= {1'b0, span_mag});

  assign quot_x     = SAT_W'(quot);
  assign quot_neg_x = '0 - quot_x;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r   <= kind;
      sample_r <= sample_value;
      goal_r   <= goal_position;
    end
    if (cmd.mul) begin
      prod_r    <= diff_s * stroke_s;
      span_mag  <= span_abs[CAL_W-1:0];
      span_neg  <= span_s[CAL_W];
      span_zero <= (span_s == '0);
    end
    if (cmd.init) begin
      quot     <= prod_mag[MAG_W-1:0];
      rem      <= '0;
      quot_neg <= prod_r[PROD_W-1] ^ span_neg;
    end
    if (cmd.step) begin
      quot <= {quot[MAG_W-2:0], rem_ge};
      rem  <= rem_ge ? CAL_W'(rem_shift - {1'b0, span_mag}) : rem_shift[CAL_W-1:0];
    end
    if (cmd.sat) begin
      if (span_zero) begin
        pos_r <= '0;
      end else if (!quot_neg) begin
        pos_r <= (quot_x > POS_MAX_X) ? POS_MAX_V : $signed(quot_x[POS_BITS-1:0]);
      end else begin
        pos_r <= (quot_x > POS_MIN_MAG) ? POS_MIN_V : $signed(quot_neg_x[POS_BITS-1:0]);
      end
    end
  end

  assign elapsed_inc = (&elapsed) ? elapsed : (elapsed + 1'b1);
  assign track_err   = {target_reg[POS_BITS-1], target_reg} - {pos_r[POS_BITS-1], pos_r};
  assign err_mag     = track_err[ERR_W-1] ? (~track_err + 1'b1) : track_err;
  assign goal_err    = {goal_r[POS_BITS-1], goal_r} - {pos_r[POS_BITS-1], pos_r};

  always_comb begin
    target_next  = target_reg;
    ready_next   = ready_reg;
    extend_next  = extend_reg;
    retract_next = retract_reg;
    elapsed_next = elapsed;
    cause_next   = CAUSE_NONE;
    case (kind_r)
      KIND_TICK: begin
        elapsed_next = elapsed_inc;
        if (TCMP_W'(elapsed_inc) > TCMP_W'(timeout)) begin
          cause_next = CAUSE_TIMEOUT;
        end else if (ECMP_W'(err_mag) < ECMP_W'(tolerance)) begin
          cause_next = CAUSE_REACHED;
        end
      end
      KIND_GOTO: begin
        // A new goal is taken only while stopped.
        if (ready_reg) begin
          target_next  = goal_r;
          extend_next  = !goal_err[ERR_W-1] && (goal_err != '0);
          retract_next = !(!goal_err[ERR_W-1] && (goal_err != '0));
          ready_next   = 1'b0;
          elapsed_next = '0;
        end
      end
      KIND_STOP: begin
        cause_next = CAUSE_STOP;
      end
      default: begin
      end
    endcase
    if (cause_next != CAUSE_NONE) begin
      extend_next  = 1'b0;
      retract_next = 1'b0;
      target_next  = pos_r;
      ready_next   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_reg  <= '0;
      ready_reg   <= 1'b1;
      extend_reg  <= 1'b0;
      retract_reg <= 1'b0;
      elapsed     <= '0;
    end else if (cmd.update) begin
      target_reg  <= target_next;
      ready_reg   <= ready_next;
      extend_reg  <= extend_next;
      retract_reg <= retract_next;
      elapsed     <= elapsed_next;
    end
  end

  assign out_busy = out_ch.valid && !out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (cmd.update) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_ch.extend_drive  <= extend_next;
      out_ch.retract_drive <= retract_next;
      out_ch.ready_flag    <= ready_next;
      out_ch.target_out    <= target_next;
      out_ch.position_out  <= pos_r;
      out_ch.stop_cause    <= cause_next;
    end
  end

  a_drives_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(extend_reg && retract_reg))
    else $error("extend and retract driven together");

  a_ready_idle_drives: assert property (@(posedge clk) disable iff (rst)
    ready_reg |-> (!extend_reg && !retract_reg))
    else $error("drive active while ready");

  a_update_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.update |=> (out_ch.valid && out_ch.ready_flag == ready_reg))
    else $error("result register does not match controller state");

endmodule
`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import apc_pkg::*;

  localparam int ADC_W = ADC_BITS_DEF;
  localparam int POS_W = POS_BITS_DEF;
  localparam int TIME_W = TIME_BITS_DEF;

  // Kind code with no meaning; the block must ignore it.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    logic             extend;
    logic             retract;
    logic             ready;
    logic [POS_W-1:0] target;
    logic [POS_W-1:0] position;
    logic [CAUSE_W-1:0] cause;
  } drive_status_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  apc_in_if  #(.ADC_BITS(ADC_W), .POS_BITS(POS_W)) in_ch ();
  apc_out_if #(.POS_BITS(POS_W)) out_ch ();

  actuator_position_controller #(
    .ADC_BITS(ADC_W),
    .POS_BITS(POS_W),
    .TIME_BITS(TIME_W)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Local copy of the calibration and the controller state.
  logic [CAL_W-1:0]     cal_low = CAL_LOW_RST;
  logic [CAL_W-1:0]     cal_high = CAL_HIGH_RST;
  logic [STROKE_W-1:0]  stroke = STROKE_RST;
  logic [TIMEOUT_W-1:0] timeout_limit = TIMEOUT_RST;
  logic [TOL_W-1:0]     tol_band = TOL_RST;

  logic signed [POS_W-1:0] target_pos = '0;
  logic                    motion_ready = 1'b1;
  logic                    extend_on = 1'b0;
  logic                    retract_on = 1'b0;
  logic [TIME_W-1:0]       elapsed_ticks = '0;

  drive_status_t awaited_status[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int error_count = 0;
  int requests_sent = 0;
  int results_checked = 0;
  int moves_started = 0;
  int stops_reached = 0;
  int stops_timeout = 0;
  int stops_command = 0;

  function automatic logic signed [POS_W-1:0] map_reading(input logic [ADC_W-1:0] raw);
    longint lo, hi, span, v;
    lo = cal_low;
    hi = cal_high;
    span = hi - lo;
    if (span == 0) return '0;
    v = (longint'(raw) - lo) * longint'(stroke) / span;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[POS_W-1:0];
  endfunction

  function automatic void halt_motion(input logic signed [POS_W-1:0] pos);
    extend_on = 1'b0;
    retract_on = 1'b0;
    target_pos = pos;
    motion_ready = 1'b1;
  endfunction

  function automatic void controller_step(input logic [KIND_W-1:0] kind,
                                          input logic [ADC_W-1:0] raw,
                                          input logic signed [POS_W-1:0] goal);
    logic signed [POS_W-1:0] pos;
    logic [CAUSE_W-1:0] cause;
    longint err;
    drive_status_t s;
    pos = map_reading(raw);
    cause = CAUSE_NONE;
    case (kind)
      KIND_TICK: begin
        if (elapsed_ticks != '1) elapsed_ticks = elapsed_ticks + 1'b1;
        err = longint'(target_pos) - longint'(pos);
        if (err < 0) err = -err;
        if (elapsed_ticks > timeout_limit) begin
          halt_motion(pos);
          cause = CAUSE_TIMEOUT;
          stops_timeout++;
        end else if (err < longint'(tol_band)) begin
          halt_motion(pos);
          cause = CAUSE_REACHED;
          stops_reached++;
        end
      end
      KIND_GOTO: begin
        // A new goal is taken only while stopped.
        if (motion_ready) begin
          target_pos = goal;
          extend_on = (longint'(goal) - longint'(pos)) > 0;
          retract_on = !extend_on;
          motion_ready = 1'b0;
          elapsed_ticks = '0;
          moves_started++;
        end
      end
      KIND_STOP: begin
        halt_motion(pos);
        cause = CAUSE_STOP;
        stops_command++;
      end
      default: begin
      end
    endcase
    s.extend = extend_on;
    s.retract = retract_on;
    s.ready = motion_ready;
    s.target = target_pos;
    s.position = pos;
    s.cause = cause;
    awaited_status.push_back(s);
  endfunction

  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [ADC_W-1:0] raw,
                              input logic signed [POS_W-1:0] goal);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.sample_value <= raw;
    in_ch.goal_position <= goal;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    controller_step(kind, raw, goal);
    requests_sent++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (awaited_status.size() != 0) @(posedge clk);
  endtask

  // Rewrites all five registers back to back; only called with nothing in flight.
  task automatic set_config(input logic [CFG_DATA_W-1:0] low_w, input logic [CFG_DATA_W-1:0] high_w,
                            input logic [CFG_DATA_W-1:0] stroke_w,
                            input logic [CFG_DATA_W-1:0] timeout_w,
                            input logic [CFG_DATA_W-1:0] tol_w);
    drain_results();
    cfg_write <= 1'b1;
    cfg_index <= REG_CAL_LOW;
    cfg_data <= low_w;
    @(posedge clk);
    cfg_index <= REG_CAL_HIGH;
    cfg_data <= high_w;
    @(posedge clk);
    cfg_index <= REG_STROKE;
    cfg_data <= stroke_w;
    @(posedge clk);
    cfg_index <= REG_TIMEOUT;
    cfg_data <= timeout_w;
    @(posedge clk);
    cfg_index <= REG_TOL;
    cfg_data <= tol_w;
    @(posedge clk);
    cfg_write <= 1'b0;
    cal_low = low_w[CAL_W-1:0];
    cal_high = high_w[CAL_W-1:0];
    stroke = stroke_w[STROKE_W-1:0];
    timeout_limit = timeout_w[TIMEOUT_W-1:0];
    tol_band = tol_w[TOL_W-1:0];
  endtask

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    drive_status_t want;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (awaited_status.size() == 0) begin
        $error("result with no request outstanding");
        error_count++;
      end else begin
        want = awaited_status.pop_front();
        check_field("extend_drive", want.extend, out_ch.extend_drive);
        check_field("retract_drive", want.retract, out_ch.retract_drive);
        check_field("ready_flag", want.ready, out_ch.ready_flag);
        check_field("target_out", $signed(want.target), out_ch.target_out);
        check_field("position_out", $signed(want.position), out_ch.position_out);
        check_field("stop_cause", want.cause, out_ch.stop_cause);
        results_checked++;
      end
    end
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Default calibration: go-to both ways, a busy go-to, the unused kind,
  // a goal already at the position, command stops and a reach stop.
  task automatic test_basic_motion();
    send_request(KIND_TICK, 12'd0, 16'sd0);
    send_request(KIND_GOTO, 12'd4095, 16'sd32767);
    send_request(KIND_GOTO, 12'd100, -16'sd5);
    send_request(KIND_UNUSED, 12'd2048, 16'sd77);
    send_request(KIND_TICK, 12'd4095, 16'sd0);
    send_request(KIND_STOP, 12'd2048, 16'sd0);
    send_request(KIND_GOTO, 12'd0, -16'sd32768);
    send_request(KIND_STOP, 12'd0, 16'sd0);
    send_request(KIND_GOTO, 12'd2048, 16'sd150);
    send_request(KIND_TICK, 12'd2048, 16'sd0);
  endtask

  // Saturation both ways, inverted and zero-width ranges, zero stroke, and
  // register data with bits above the register width.
  task automatic test_mapping_corners();
    set_config(24'd4096, 24'd4097, 24'd4095, 24'd60000, 24'd5);
    send_request(KIND_TICK, 12'd0, 16'sd0);
    send_request(KIND_TICK, 12'd4095, 16'sd0);
    set_config(24'd0, 24'd1, 24'd4095, 24'd60000, 24'd5);
    send_request(KIND_TICK, 12'd4095, 16'sd0);
    set_config(24'd8191, 24'd0, 24'd4095, 24'd60000, 24'd5);
    send_request(KIND_TICK, 12'd0, 16'sd0);
    set_config(24'd2000, 24'd2000, 24'd300, 24'd60000, 24'd5);
    send_request(KIND_TICK, 12'd1234, 16'sd0);
    send_request(KIND_GOTO, 12'd0, 16'sd1);
    send_request(KIND_STOP, 12'd4095, 16'sd0);
    set_config(24'hFFE064, 24'd4096, 24'hFFF000, 24'd60000, 24'd5);
    send_request(KIND_TICK, 12'd4095, 16'sd0);
  endtask

  task automatic test_timeout_and_band();
    set_config(24'd100, 24'd4000, 24'd300, 24'd0, 24'd0);
    send_request(KIND_GOTO, 12'd0, 16'sd100);
    send_request(KIND_TICK, 12'd0, 16'sd0);
    set_config(24'd100, 24'd4000, 24'd300, 24'd3, 24'd0);
    send_request(KIND_GOTO, 12'd4095, -16'sd100);
    send_request(KIND_TICK, 12'd4095, 16'sd0);
    send_request(KIND_TICK, 12'd3000, 16'sd0);
    send_request(KIND_TICK, 12'd2000, 16'sd0);
    send_request(KIND_TICK, 12'd1000, 16'sd0);
    set_config(24'd100, 24'd4000, 24'd300, 24'hFFFFFF, 24'd4095);
    send_request(KIND_GOTO, 12'd2000, 16'sd0);
    send_request(KIND_TICK, 12'd3000, 16'sd0);
  endtask

  // A move toward a goal near a chosen reading, with the feedback walking
  // toward that reading one tick at a time.
  task automatic run_move();
    int goal_raw, raw, stride, g, steps;
    goal_raw = $urandom_range(4095);
    raw = $urandom_range(4095);
    g = int'(map_reading(goal_raw[ADC_W-1:0])) + int'($urandom_range(20)) - 10;
    if (g > 32767) g = 32767;
    if (g < -32768) g = -32768;
    steps = $urandom_range(14, 2);
    if (!motion_ready)
      send_request(KIND_STOP, ADC_W'($urandom_range(4095)), POS_W'($urandom));
    send_request(KIND_GOTO, raw[ADC_W-1:0], g[POS_W-1:0]);
    repeat (steps) begin
      stride = $urandom_range(600, 1);
      if (raw < goal_raw) raw = (goal_raw - raw < stride) ? goal_raw : raw + stride;
      else raw = (raw - goal_raw < stride) ? goal_raw : raw - stride;
      if ($urandom_range(99) < 5) send_request(KIND_STOP, raw[ADC_W-1:0], POS_W'($urandom));
      else send_request(KIND_TICK, raw[ADC_W-1:0], POS_W'($urandom));
    end
  endtask

  task automatic test_random_motion(input int count, input int idle_pct, input int stall_pct);
    int first;
    first = requests_sent;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    while (requests_sent - first < count) begin
      if ($urandom_range(99) < 80) run_move();
      else send_request(KIND_W'($urandom_range(3)), ADC_W'($urandom_range(4095)),
                        POS_W'($urandom));
    end
    drain_results();
  endtask

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.kind <= KIND_TICK;
    in_ch.sample_value <= '0;
    in_ch.goal_position <= '0;
    cfg_write <= 1'b0;
    cfg_index <= REG_CAL_LOW;
    cfg_data <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_basic_motion();
    test_mapping_corners();
    test_timeout_and_band();

    set_config(24'd0, 24'd4096, 24'd300, 24'd60000, 24'd5);
    test_random_motion(120, 0, 0);
    set_config(24'd200, 24'd3900, 24'd4095, 24'd40, 24'd60);
    test_random_motion(120, 58, 0);
    set_config(24'd4000, 24'd100, 24'd2000, 24'd8, 24'd12);
    test_random_motion(120, 0, 58);
    set_config(24'd8191, 24'd0, 24'd4095, 24'hFFFFFF, 24'd4095);
    test_random_motion(120, 29, 29);

    drain_results();
    repeat (40) @(posedge clk);
    if (awaited_status.size() != 0) begin
      $error("%0d results never arrived", awaited_status.size());
      error_count++;
    end
    $display("testbench: %0d requests, %0d results checked, %0d moves started",
             requests_sent, results_checked, moves_started);
    $display("testbench: stops by reach %0d, by timeout %0d, by command %0d",
             stops_reached, stops_timeout, stops_command);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("testbench: timed out");
    $display("testbench: done, errors");
    $finish;
  end

endmodule
